// File: src/tlm_pkg.sv
// ----------------------------------------------------------------------------
// tlm_pkg: shared types and constants of the two-layer perceptron
// Command codes, payload widths and default dimensions.
// ----------------------------------------------------------------------------
package tlm_pkg;

  localparam int unsigned InDimDef  = 4;
  localparam int unsigned HidDimDef = 64;
  localparam int unsigned OutDimDef = 1;
  localparam int unsigned LanesDef  = 8;

  // Accumulator width: 32-bit products summed over up to 256 terms plus bias
  localparam int unsigned AccW = 42;

  typedef enum logic [2:0] {
    CmdFeature = 3'd0,
    CmdW1      = 3'd1,
    CmdB1      = 3'd2,
    CmdW2      = 3'd3,
    CmdB2      = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StL1Run,
    StL1Drain,
    StL2Run,
    StL2Drain,
    StEmit
  } state_e;

  // Control handed from the sequencer to the cell row
  typedef struct packed {
    logic clear;   // load bias into accumulator
    logic shift;   // take the neighbour's accumulator
    logic mac;     // accumulate one product
  } cell_ctrl_t;

  // ReLU, floor to Q8.8, saturate to 32767
  function automatic logic [14:0] relu_q88(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] q;
    q = acc >>> 8;
    if (acc <= 0) begin
      return 15'd0;
    end else if (q > 32767) begin
      return 15'h7fff;
    end else begin
      return q[14:0];
    end
  endfunction

endpackage

// File: src/tlm_if.sv
// ----------------------------------------------------------------------------
// tlm_in_if / tlm_out_if: valid-ready request channels
// Input request carries load or feature words; output carries results.
// ----------------------------------------------------------------------------
interface tlm_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic [7:0]        row;
  logic [7:0]        col;
  logic signed [15:0] value;
  logic              last;
  modport source (output valid, cmd, row, col, value, last, input ready);
  modport sink   (input valid, cmd, row, col, value, last, output ready);
endinterface

interface tlm_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_index;
  logic [14:0] out_value;
  logic        out_last;
  modport source (output valid, out_index, out_value, out_last, input ready);
  modport sink   (input valid, out_index, out_value, out_last, output ready);
endinterface

// File: src/two_layer_mlp_relu.sv
// ----------------------------------------------------------------------------
// two_layer_mlp_relu: two-layer perceptron inference with ReLU, Q8.8
// Load requests fill weight/bias RAMs; a feature with last runs one sample.
// ----------------------------------------------------------------------------
// Loads and non-final features are stored as they are accepted. A final
// feature starts a sample on a chain of HID_DIM multiply-accumulate cells,
// one per hidden neuron, each holding its layer-one weights and bias in a
// small RAM. The feature words, then the constant 1.0 that scales the bias,
// enter the first cell and move one cell a cycle. The sums then shift out
// through the first cell into the hidden RAM, one neuron a cycle. Layer two
// streams one hidden value a cycle from that RAM into OUT_DIM cells, a drain
// state settles the sums, and OUT_DIM results leave one per accepted cycle.
// No input is taken during a sample, so the input is held off until the last
// result is accepted. The lane count in the package is not used: every
// neuron owns a cell.
module two_layer_mlp_relu #(
  parameter int unsigned IN_DIM  = tlm_pkg::InDimDef,
  parameter int unsigned HID_DIM = tlm_pkg::HidDimDef,
  parameter int unsigned OUT_DIM = tlm_pkg::OutDimDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  tlm_in_if.sink    in_i,
  tlm_out_if.source out_o
);
  localparam int unsigned IW  = (IN_DIM  > 1) ? $clog2(IN_DIM)  : 1;
  localparam int unsigned HW  = (HID_DIM > 1) ? $clog2(HID_DIM) : 1;
  localparam int unsigned OW  = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
  localparam int unsigned W2D = HID_DIM * OUT_DIM;
  localparam int unsigned W2W = (W2D > 1) ? $clog2(W2D) : 1;
  localparam int unsigned W1D = IN_DIM + 1;
  localparam int unsigned W1W = $clog2(W1D);
  localparam int unsigned CW  = $clog2(IN_DIM + HID_DIM + 2);
  localparam int unsigned AW  = tlm_pkg::AccW;

  tlm_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            acc_in;

  assign acc_in = in_i.valid && in_i.ready;

  logic signed [15:0] b2_q [OUT_DIM];
  logic signed [15:0] feat_q [IN_DIM];

  // Layer-two biases, one per output
  always_ff @(posedge clk_i) begin
    if (acc_in && in_i.cmd == tlm_pkg::CmdB2 && 32'(in_i.col) < OUT_DIM) begin
      b2_q[in_i.col[OW-1:0]] <= in_i.value;
    end
  end

  // Feature vector, reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < IN_DIM; i++) feat_q[i] <= '0;
    end else if (acc_in && in_i.cmd == tlm_pkg::CmdFeature
                 && 32'(in_i.row) < IN_DIM) begin
      feat_q[in_i.row[IW-1:0]] <= in_i.value;
    end
  end

  // Hidden and layer-two weight RAMs
  logic          hid_we;
  logic [HW-1:0] hid_waddr, hid_raddr;
  logic [15:0]   hid_wdata, hid_rdata;
  logic          w2_we;
  logic [W2W-1:0] w2_waddr;
  logic [W2W-1:0] w2_raddr [OUT_DIM];
  logic [15:0]   w2_rdata [OUT_DIM];

  tlm_ram #(.Width(16), .Depth(HID_DIM)) u_hid (
    .clk_i, .we_i(hid_we), .waddr_i(hid_waddr), .wdata_i(hid_wdata),
    .raddr_i(hid_raddr), .rdata_o(hid_rdata)
  );

  assign w2_we = acc_in && in_i.cmd == tlm_pkg::CmdW2
                 && 32'(in_i.row) < HID_DIM && 32'(in_i.col) < OUT_DIM;
  assign w2_waddr = W2W'(32'(in_i.row) * OUT_DIM + 32'(in_i.col));

  for (genvar k = 0; k < OUT_DIM; k++) begin : g_w2
    tlm_ram #(.Width(16), .Depth(W2D)) u_w2 (
      .clk_i, .we_i(w2_we), .waddr_i(w2_waddr), .wdata_i(in_i.value),
      .raddr_i(w2_raddr[k]), .rdata_o(w2_rdata[k])
    );
    assign w2_raddr[k] = W2W'(32'(hid_raddr) * OUT_DIM + k);
  end

  // Layer-one chain: feature words, then 1.0 for the bias, enter cell 0
  tlm_pkg::cell_ctrl_t  c1_ctrl [HID_DIM];
  logic signed [15:0]   c1_x [HID_DIM+1];
  logic signed [AW-1:0] c1_acc [HID_DIM+1];
  logic                 l1_start;
  logic                 w1_load;

  assign l1_start = acc_in && in_i.cmd == tlm_pkg::CmdFeature && in_i.last;
  assign w1_load  = acc_in && ((in_i.cmd == tlm_pkg::CmdW1 && 32'(in_i.row) < IN_DIM)
                               || in_i.cmd == tlm_pkg::CmdB1);
  assign c1_x[0]  = (state_q != tlm_pkg::StL1Run) ? 16'sd0
                  : (32'(cnt_q) < IN_DIM)  ? feat_q[cnt_q[IW-1:0]]
                  : (32'(cnt_q) == IN_DIM) ? 16'sd256 : 16'sd0;
  assign c1_acc[HID_DIM] = '0;

  for (genvar h = 0; h < HID_DIM; h++) begin : g_c1
    logic [CW-1:0]      step;
    logic               w1_we;
    logic [W1W-1:0]     w1_waddr, w1_raddr;
    logic signed [15:0] w1_rdata;
    assign step = cnt_q - CW'(h);
    // Weights at their input index, bias after the last one
    assign w1_we    = w1_load && 32'(in_i.col) == h;
    assign w1_waddr = (in_i.cmd == tlm_pkg::CmdB1) ? W1W'(IN_DIM) : W1W'(in_i.row);
    // Address from the next count so the registered read meets the word
    assign w1_raddr = W1W'(cnt_d - CW'(h));
    // Cell h sees step i once the word has passed the h cell registers before it
    assign c1_ctrl[h].clear = l1_start;
    assign c1_ctrl[h].shift = state_q == tlm_pkg::StL1Drain;
    assign c1_ctrl[h].mac   = state_q == tlm_pkg::StL1Run && cnt_q >= CW'(h)
                              && 32'(step) <= IN_DIM;
    tlm_ram #(.Width(16), .Depth(W1D)) u_w1 (
      .clk_i, .we_i(w1_we), .waddr_i(w1_waddr), .wdata_i(in_i.value),
      .raddr_i(w1_raddr), .rdata_o(w1_rdata)
    );
    tlm_cell u_cell (
      .clk_i, .rst_ni, .ctrl_i(c1_ctrl[h]), .x_i(c1_x[h]),
      .w_i(w1_rdata), .bias_i(16'sd0), .acc_i(c1_acc[h+1]),
      .x_o(c1_x[h+1]), .acc_o(c1_acc[h])
    );
  end

  // Hidden write-back: sums shift out of cell 0, one neuron per cycle
  assign hid_we    = state_q == tlm_pkg::StL1Drain;
  assign hid_waddr = cnt_q[HW-1:0];
  assign hid_wdata = {1'b0, tlm_pkg::relu_q88(c1_acc[0])};
  assign hid_raddr = cnt_q[HW-1:0];

  // Layer-two cells: one per output, fed by the RAM read port
  tlm_pkg::cell_ctrl_t c2_ctrl;
  logic signed [AW-1:0] c2_acc [OUT_DIM];
  logic [OW-1:0]        emit_idx_q;

  assign c2_ctrl.clear = state_q == tlm_pkg::StL1Drain && 32'(cnt_q) == HID_DIM - 1;
  assign c2_ctrl.shift = 1'b0;
  assign c2_ctrl.mac   = state_q == tlm_pkg::StL2Run && cnt_q >= CW'(1)
                         && 32'(cnt_q) <= HID_DIM;

  for (genvar k = 0; k < OUT_DIM; k++) begin : g_c2
    logic signed [15:0] xo;
    tlm_cell u_cell (
      .clk_i, .rst_ni, .ctrl_i(c2_ctrl), .x_i(hid_rdata), .w_i(w2_rdata[k]),
      .bias_i(b2_q[k]), .acc_i('0), .x_o(xo), .acc_o(c2_acc[k])
    );
  end

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + CW'(1);
    unique case (state_q)
      tlm_pkg::StIdle: begin
        cnt_d = '0;
        if (l1_start) state_d = tlm_pkg::StL1Run;
      end
      tlm_pkg::StL1Run: begin
        if (32'(cnt_q) == IN_DIM + HID_DIM - 1) begin
          state_d = tlm_pkg::StL1Drain;
          cnt_d   = '0;
        end
      end
      tlm_pkg::StL1Drain: begin
        if (32'(cnt_q) == HID_DIM - 1) begin
          state_d = tlm_pkg::StL2Run;
          cnt_d   = '0;
        end
      end
      tlm_pkg::StL2Run: begin
        if (32'(cnt_q) == HID_DIM) begin
          state_d = tlm_pkg::StL2Drain;
          cnt_d   = '0;
        end
      end
      tlm_pkg::StL2Drain: begin
        state_d = tlm_pkg::StEmit;
        cnt_d   = '0;
      end
      tlm_pkg::StEmit: begin
        cnt_d = cnt_q;
        if (out_o.ready && 32'(emit_idx_q) == OUT_DIM - 1) state_d = tlm_pkg::StIdle;
      end
      default: state_d = tlm_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tlm_pkg::StIdle;
      cnt_q      <= '0;
      emit_idx_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q != tlm_pkg::StEmit) begin
        emit_idx_q <= '0;
      end else if (out_o.ready) begin
        emit_idx_q <= emit_idx_q + OW'(1);
      end
    end
  end

  // Outputs
  always_comb begin
    in_i.ready      = state_q == tlm_pkg::StIdle;
    out_o.valid     = state_q == tlm_pkg::StEmit;
    out_o.out_index = 4'(emit_idx_q);
    out_o.out_value = tlm_pkg::relu_q88(c2_acc[emit_idx_q]);
    out_o.out_last  = 32'(emit_idx_q) == OUT_DIM - 1;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready) else $error("input taken during a sample");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    l1_start |=> state_q == tlm_pkg::StL1Run) else $error("sample did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.out_last) |=> state_q == tlm_pkg::StIdle)
    else $error("no return to idle after last result");
endmodule

// File: src/tlm_ram.sv
// ----------------------------------------------------------------------------
// tlm_ram: generic single-port-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: src/tlm_cell.sv
// ----------------------------------------------------------------------------
// tlm_cell: one multiply-accumulate cell of the chain
// Accumulates one neuron; passes the feature word on to its neighbour.
// ----------------------------------------------------------------------------
module tlm_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tlm_pkg::cell_ctrl_t              ctrl_i,
  input  logic signed [15:0]               x_i,
  input  logic signed [15:0]               w_i,
  input  logic signed [15:0]               bias_i,
  input  logic signed [tlm_pkg::AccW-1:0]  acc_i,
  output logic signed [15:0]               x_o,
  output logic signed [tlm_pkg::AccW-1:0]  acc_o
);
  logic signed [15:0]              x_q;
  logic signed [31:0]              prod;
  logic signed [tlm_pkg::AccW-1:0] acc_d, acc_q;

  assign prod = x_i * w_i;

  // Clear to bias, take the neighbour's sum, or add one product
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = tlm_pkg::AccW'(bias_i) <<< 8;
    end else if (ctrl_i.shift) begin
      acc_d = acc_i;
    end else if (ctrl_i.mac) begin
      acc_d = acc_q + tlm_pkg::AccW'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
    end else begin
      x_q <= x_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign x_o   = x_q;
  assign acc_o = acc_q;
endmodule
